// ----- hdl/dofa_pkg.sv -----
// Shared types and codes for the drop-oldest record queue.
`timescale 1ns / 1ps
`default_nettype none

package dofa_pkg;

    // Widths of the fixed record fields.
    localparam int ID_W      = 32;
    localparam int TIME_W    = 32;
    localparam int BYTE_W    = 8;
    localparam int SECONDS_W = 16;
    localparam int COUNT_W   = 5;

    // Stream widths, padded to whole bytes.
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 112;

    // Operation codes carried on the input tuser.
    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_ACK     = 1'b1
    } op_t;

    // One stored record; id sits in the lowest bits, as on the input tdata.
    typedef struct packed {
        logic [SECONDS_W-1:0] work_seconds;
        logic [BYTE_W-1:0]    actual_value;
        logic                 is_timed;
        logic [BYTE_W-1:0]    set_number;
        logic [BYTE_W-1:0]    movement;
        logic [TIME_W-1:0]    performed_time;
        logic [ID_W-1:0]      set_id;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    // One result item as packed on the output tdata, lowest field last.
    typedef struct packed {
        logic                 ack_matched;
        logic                 evicted;
        logic [SECONDS_W-1:0] oldest_work_seconds;
        logic [BYTE_W-1:0]    oldest_actual;
        logic                 oldest_timed;
        logic [BYTE_W-1:0]    oldest_set_number;
        logic [BYTE_W-1:0]    oldest_movement;
        logic [TIME_W-1:0]    oldest_time;
        logic [ID_W-1:0]      oldest_id;
        logic [COUNT_W-1:0]   entry_count;
    } res_t;

    // Sequencer states.
    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_SCAN_RD  = 7'b0000010,
        ST_SCAN_CMP = 7'b0000100,
        ST_MOVE_RD  = 7'b0001000,
        ST_MOVE_WR  = 7'b0010000,
        ST_HEAD_RD  = 7'b0100000,
        ST_RESULT   = 7'b1000000
    } state_t;

endpackage : dofa_pkg

`default_nettype wire

// ----- hdl/drop_oldest_fifo_ack_by_id.sv -----
// Top level: bounded record queue that drops its oldest record when full
// and removes the first record whose id matches an acknowledge.
//
//  channel   dir  handshake           tdata / tuser
//  s_axis    in   s_tvalid/s_tready   set_id, performed_time, record fields; tuser opcode
//  m_axis    out  m_tvalid/m_tready   count, oldest record, flags; tuser has_oldest
//
// Records sit in a circular buffer in one RAM with a registered read port.
// An enqueue writes its record on accept, then reads the head slot (ST_HEAD_RD)
// and fills the result register (ST_RESULT). An acknowledge scans one slot at a
// time (ST_SCAN_RD, ST_SCAN_CMP) and, on a match, compacts one slot at a time
// (ST_MOVE_RD, ST_MOVE_WR); the single RAM port pair and one id comparator set
// that pace. Reset empties the queue at once. A result that is not taken holds
// the sequencer before the next result is written, while the next item may already be accepted.
`timescale 1ns / 1ps
`default_nettype none

module drop_oldest_fifo_ack_by_id #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // set_id, performed_time, movement, set_number, is_timed, actual_value,
    // work_seconds, zero pad
    input  wire [dofa_pkg::IN_DATA_W-1:0]    s_tdata,
    // opcode
    input  wire                              s_tuser,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // entry_count, oldest_id, oldest_time, oldest_movement, oldest_set_number,
    // oldest_timed, oldest_actual, oldest_work_seconds, evicted, ack_matched
    output logic [dofa_pkg::OUT_DATA_W-1:0]  m_tdata,
    // has_oldest
    output logic                             m_tuser
);

    import dofa_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    // Next slot in the circular buffer.
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == LAST_PTR)
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    state_t           state_reg, state_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] pos_reg, pos_next;
    logic [PTR_W-1:0] idx_reg, idx_next;
    logic             evicted_reg, evicted_next;
    logic             matched_reg, matched_next;
    logic [ID_W-1:0]  key_reg, key_next;
    logic             out_valid_reg, out_valid_next;
    res_t             out_res_reg, out_res_next;
    logic             out_has_reg, out_has_next;

    logic             s_accept;
    logic             out_free;
    logic             last_idx;
    logic             id_hit;
    logic             ram_wr_en;
    logic [PTR_W-1:0] ram_wr_addr;
    rec_t             ram_wr_data;
    logic             ram_rd_en;
    logic [PTR_W-1:0] ram_rd_addr;
    logic [REC_W-1:0] ram_rd_raw;
    rec_t             rd_rec;
    rec_t             in_rec;

    dofa_ram #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_slots (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_raw)
    );

    assign rd_rec   = rec_t'(ram_rd_raw);
    assign in_rec   = rec_t'(s_tdata[REC_W-1:0]);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // Shared compare unit: id match and end-of-queue test.
    assign id_hit   = (rd_rec.set_id == key_reg);
    assign last_idx = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    // Sequencer and RAM port control.
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        evicted_next   = evicted_reg;
        matched_next   = matched_reg;
        key_next       = key_reg;
        out_res_next   = out_res_reg;
        out_has_next   = out_has_reg;
        out_valid_next = out_valid_reg && !m_tready;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = pos_reg;
        ram_wr_data    = rd_rec;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = pos_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    key_next     = in_rec.set_id;
                    evicted_next = 1'b0;
                    matched_next = 1'b0;
                    pos_next     = head_reg;
                    idx_next     = '0;
                    if (op_t'(s_tuser) == OP_ENQUEUE)
                    begin
                        // Append at the tail; a full queue overwrites its oldest.
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = tail_reg;
                        ram_wr_data = in_rec;
                        tail_next   = ptr_inc(tail_reg);
                        if (count_reg == FULL_CNT)
                        begin
                            head_next    = ptr_inc(head_reg);
                            evicted_next = 1'b1;
                        end
                        else
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                        state_next = ST_HEAD_RD;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = ST_HEAD_RD;
                    end
                    else
                    begin
                        state_next = ST_SCAN_RD;
                    end
                end
            end

            ST_SCAN_RD:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = pos_reg;
                state_next  = ST_SCAN_CMP;
            end

            ST_SCAN_CMP:
            begin
                if (id_hit)
                begin
                    matched_next = 1'b1;
                    state_next   = ST_MOVE_RD;
                end
                else if (last_idx)
                begin
                    state_next = ST_HEAD_RD;
                end
                else
                begin
                    pos_next   = ptr_inc(pos_reg);
                    idx_next   = idx_reg + PTR_W'(1);
                    state_next = ST_SCAN_RD;
                end
            end

            ST_MOVE_RD:
            begin
                // Close the gap: fetch the next newer slot, or finish.
                if (last_idx)
                begin
                    tail_next  = pos_reg;
                    count_next = count_reg - CNT_W'(1);
                    state_next = ST_HEAD_RD;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = ptr_inc(pos_reg);
                    state_next  = ST_MOVE_WR;
                end
            end

            ST_MOVE_WR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = pos_reg;
                ram_wr_data = rd_rec;
                pos_next    = ptr_inc(pos_reg);
                idx_next    = idx_reg + PTR_W'(1);
                state_next  = ST_MOVE_RD;
            end

            ST_HEAD_RD:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = head_reg;
                state_next  = ST_RESULT;
            end

            ST_RESULT:
            begin
                // The read data holds until the output register is free.
                if (out_free)
                begin
                    out_res_next             = '0;
                    out_res_next.entry_count = COUNT_W'(count_reg);
                    out_res_next.evicted     = evicted_reg;
                    out_res_next.ack_matched = matched_reg;
                    out_has_next             = (count_reg != '0);
                    if (count_reg != '0)
                    begin
                        out_res_next.oldest_id           = rd_rec.set_id;
                        out_res_next.oldest_time         = rd_rec.performed_time;
                        out_res_next.oldest_movement     = rd_rec.movement;
                        out_res_next.oldest_set_number   = rd_rec.set_number;
                        out_res_next.oldest_timed        = rd_rec.is_timed;
                        out_res_next.oldest_actual       = rd_rec.actual_value;
                        out_res_next.oldest_work_seconds = rd_rec.work_seconds;
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        idx_reg     <= idx_next;
        evicted_reg <= evicted_next;
        matched_reg <= matched_next;
        key_reg     <= key_next;
        out_res_reg <= out_res_next;
        out_has_reg <= out_has_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_res_reg);
    assign m_tuser  = out_has_reg;

`ifndef ASSERT_OFF
    // The queue never holds more records than it has slots.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("record count above queue depth");

    // Tail always sits count slots after head in the circular buffer.
    a_tail_track: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |->
        ((int'(head_reg) + int'(count_reg) == int'(tail_reg)) ||
         (int'(head_reg) + int'(count_reg) == int'(tail_reg) + QUEUE_DEPTH)))
        else $error("tail pointer out of step with head and count");

    // An enqueue into a queue with room grows it by one record.
    a_enq_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && (op_t'(s_tuser) == OP_ENQUEUE) && (count_reg != FULL_CNT))
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("enqueue did not add a record");

    // Finishing a compaction removes exactly one record.
    a_ack_shrink: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_MOVE_RD) && last_idx)
        |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("acknowledge did not remove one record");
`endif

endmodule : drop_oldest_fifo_ack_by_id

`default_nettype wire

// ----- hdl/dofa_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module dofa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      clk,
    input  wire                      wr_en,
    input  wire [$clog2(DEPTH)-1:0]  wr_addr,
    input  wire [WIDTH-1:0]          wr_data,
    input  wire                      rd_en,
    input  wire [$clog2(DEPTH)-1:0]  rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : dofa_ram

`default_nettype wire
